// ----- src/ghe_pkg.sv -----
// Shared types, constants and helpers for the gray histogram equalizer.
// Used by the top level, ghe_div and the testbench; depends on nothing else.
package ghe_pkg;

  localparam longint unsigned MAX_PIXELS = 64'd16777216;

  localparam int NUM_LEVELS = 256;
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  // running sum over all bins can reach NUM_LEVELS * MAX_PIXELS
  localparam int SUM_W      = CNT_W + LVL_W;
  localparam int REM_W      = CNT_W + LVL_W;
  localparam int DIV_STEPS  = LVL_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_PIXELS);
  localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(NUM_LEVELS - 1);

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_BUILD = 2'd1,
    OP_MAP   = 2'd2,
    OP_CLEAR = 2'd3
  } ghe_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_WR,
    S_MAP_OUT,
    S_BLD_RD,
    S_BLD_SUM,
    S_BLD_START,
    S_BLD_WAIT
  } ghe_state_t;

  typedef struct packed {
    ghe_op_t           op;
    logic [LVL_W-1:0]  pixel;
  } ghe_in_t;

  typedef struct packed {
    logic [LVL_W-1:0]  mapped_pixel;
    logic              table_built;
  } ghe_out_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  total;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [LVL_W-1:0]  quo;
  } div_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == CNT_MAX) ? v : v + CNT_W'(1);
    return r;
  endfunction

endpackage

// ----- src/gray_histogram_equalizer.sv -----
// Top level of the gray histogram equalizer: sequencer, histogram and table RAMs.
// Depends on ghe_pkg, ghe_ram and ghe_div.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid / in_stall  ghe_in_t  (op, pixel)
//   out_     output     out_valid / out_stall ghe_out_t (mapped_pixel, table_built)
//
// Clear: applied as it is accepted, with no extra state. Accumulate: bin read, then write back.
// Map: table read, then output register load, after any wait for the register to drain.
// Build: per bin, read, add to the running sum, start the 8-step divider, wait for its quotient.
// rst_n is synchronous; reset and clear drop all bin valid bits at once, no sweep.
// in_stall is high while a transaction is in work; a held result does not block
// accumulate, build or clear.
module gray_histogram_equalizer import ghe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ghe_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ghe_out_t out_data
);

  ghe_state_t             state_r, state_nxt;
  logic [LVL_W-1:0]       px_r, px_nxt;
  logic [LVL_W-1:0]       idx_r, idx_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic                   built_r, built_nxt;
  logic                   lt_filled_r, lt_filled_nxt;
  logic [NUM_LEVELS-1:0]  bin_vld_r, bin_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ghe_out_t               out_data_r, out_data_nxt;

  logic                   acc;
  logic                   stall;
  logic                   out_load;
  logic                   bin_rd_en, bin_wr_en;
  logic [LVL_W-1:0]       bin_rd_addr;
  logic [CNT_W-1:0]       bin_rd, bin_cur, bin_wr_data;
  logic                   lt_rd_en, lt_wr_en;
  logic [LVL_W-1:0]       lt_rd;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign acc = in_valid && !stall;

  ghe_ram #(.WIDTH(CNT_W), .DEPTH(NUM_LEVELS)) u_bins (
    .clk     (clk),
    .wr_en   (bin_wr_en),
    .wr_addr (px_r),
    .wr_data (bin_wr_data),
    .rd_en   (bin_rd_en),
    .rd_addr (bin_rd_addr),
    .rd_data (bin_rd)
  );

  ghe_ram #(.WIDTH(LVL_W), .DEPTH(NUM_LEVELS)) u_table (
    .clk     (clk),
    .wr_en   (lt_wr_en),
    .wr_addr (idx_r),
    .wr_data (div_rsp.quo),
    .rd_en   (lt_rd_en),
    .rd_addr (in_data.pixel),
    .rd_data (lt_rd)
  );

  ghe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // a bin never written since reset or clear reads as zero
  always_comb begin
    if (state_r == S_ACC_WR) begin
      bin_cur = bin_vld_r[px_r] ? bin_rd : '0;
    end else begin
      bin_cur = bin_vld_r[idx_r] ? bin_rd : '0;
    end
  end
  assign bin_wr_data = sat_inc(bin_cur);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_data.op)
            OP_ACCUM: state_nxt = S_ACC_WR;
            OP_BUILD: state_nxt = S_BLD_RD;
            OP_MAP:   state_nxt = S_MAP_OUT;
            OP_CLEAR: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ACC_WR:    state_nxt = S_IDLE;
      S_MAP_OUT:   if (out_load) state_nxt = S_IDLE;
      S_BLD_RD:    state_nxt = S_BLD_SUM;
      S_BLD_SUM:   state_nxt = S_BLD_START;
      S_BLD_START: state_nxt = S_BLD_WAIT;
      S_BLD_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (idx_r == TOP_LEVEL) ? S_IDLE : S_BLD_RD;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    stall         = 1'b1;
    out_load      = 1'b0;
    bin_rd_en     = 1'b0;
    bin_wr_en     = 1'b0;
    bin_rd_addr   = idx_r;
    lt_rd_en      = 1'b0;
    lt_wr_en      = 1'b0;
    div_req.start = 1'b0;
    div_req.sum   = sum_r;
    div_req.total = total_r;
    unique case (state_r)
      S_IDLE: begin
        stall       = 1'b0;
        bin_rd_addr = in_data.pixel;
        bin_rd_en   = acc && (in_data.op == OP_ACCUM);
        lt_rd_en    = acc && (in_data.op == OP_MAP);
      end
      S_ACC_WR:    bin_wr_en = 1'b1;
      S_MAP_OUT:   out_load = !out_valid_r || !out_stall;
      S_BLD_RD:    bin_rd_en = 1'b1;
      S_BLD_SUM:   ;
      S_BLD_START: div_req.start = 1'b1;
      S_BLD_WAIT:  lt_wr_en = div_rsp.done;
      default:     ;
    endcase
  end

  // datapath
  always_comb begin
    px_nxt        = px_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    total_nxt     = total_r;
    built_nxt     = built_r;
    lt_filled_nxt = lt_filled_r;
    bin_vld_nxt   = bin_vld_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (acc) begin
      case (in_data.op)
        OP_ACCUM: begin
          px_nxt    = in_data.pixel;
          total_nxt = sat_inc(total_r);
        end
        OP_BUILD: begin
          idx_nxt = '0;
          sum_nxt = '0;
        end
        OP_MAP:   ;
        OP_CLEAR: begin
          bin_vld_nxt = '0;
          total_nxt   = '0;
          built_nxt   = 1'b0;
        end
      endcase
    end

    if (state_r == S_ACC_WR) begin
      bin_vld_nxt[px_r] = 1'b1;
    end

    if (state_r == S_BLD_SUM) begin
      sum_nxt = sum_r + SUM_W'(bin_cur);
    end

    if (state_r == S_BLD_WAIT && div_rsp.done) begin
      idx_nxt = idx_r + LVL_W'(1);
      if (idx_r == TOP_LEVEL) begin
        built_nxt     = 1'b1;
        lt_filled_nxt = 1'b1;
      end
    end

    if (out_load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.mapped_pixel = lt_filled_r ? lt_rd : '0;
      out_data_nxt.table_built  = built_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      built_r     <= 1'b0;
      lt_filled_r <= 1'b0;
      bin_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      built_r     <= built_nxt;
      lt_filled_r <= lt_filled_nxt;
      bin_vld_r   <= bin_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    px_r       <= px_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // divider results only show up while the sequencer waits for them
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_BLD_WAIT)
    else $error("divider done outside build wait");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op == OP_CLEAR)
      |=> (total_r == '0 && !built_r && bin_vld_r == '0))
    else $error("clear left histogram state behind");

  a_build_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLD_WAIT && div_rsp.done && idx_r == TOP_LEVEL)
      |=> (built_r && lt_filled_r && state_r == S_IDLE))
    else $error("last table entry did not finish the build");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_MAX)
    else $error("pixel total beyond saturation limit");

endmodule

// ----- src/ghe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ghe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/ghe_div.sv -----
// Iterative divider: floor(sum * 255 / total), limited to 255, zero for zero total.
// One quotient bit per cycle. Depends on ghe_pkg.
module ghe_div import ghe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [REM_W-1:0]  dsh_r, dsh_nxt;
  logic [LVL_W-1:0]  quo_r, quo_nxt;

  logic [CNT_W-1:0]  sum_lo;
  logic [REM_W-1:0]  prod;
  logic              fits;

  assign sum_lo = req.sum[CNT_W-1:0];
  // sum * 255 as (sum << 8) - sum
  assign prod   = {sum_lo, LVL_W'(0)} - REM_W'(sum_lo);
  assign fits   = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      if (req.total == '0) begin
        quo_nxt  = '0;
        done_nxt = 1'b1;
      end else if (req.sum >= SUM_W'(req.total)) begin
        // quotient would be 255 or more
        quo_nxt  = TOP_LEVEL;
        done_nxt = 1'b1;
      end else begin
        // sum < total, so the quotient fits in LVL_W bits
        busy_nxt = 1'b1;
        rem_nxt  = prod;
        dsh_nxt  = REM_W'(req.total) << (LVL_W - 1);
        step_nxt = STEP_W'(DIV_STEPS - 1);
        quo_nxt  = '0;
      end
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[LVL_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ----- sim/gray_histogram_equalizer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for gray_histogram_equalizer: directed cases, random frames,
// output backpressure and drain pauses. Depends on ghe_pkg and the RTL under src.
module gray_histogram_equalizer_tb;
  import ghe_pkg::*;

  localparam int unsigned QUIET_LIMIT = 16000;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned SETTLE_CYC  = 3100;
  localparam int unsigned PHASE_ITEMS = 600;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ghe_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ghe_out_t out_data;

  // predictor state
  longint unsigned hist_bins [NUM_LEVELS];
  longint unsigned hist_total;
  logic [7:0]      eq_table [NUM_LEVELS];
  logic            eq_built;
  ghe_out_t        map_expect_q[$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  gray_histogram_equalizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic void predict_txn(input ghe_in_t txn);
    longint unsigned run_sum;
    longint unsigned level;
    run_sum = 0;
    case (txn.op)
      OP_ACCUM: begin
        if (hist_bins[txn.pixel] < MAX_PIXELS) hist_bins[txn.pixel]++;
        if (hist_total < MAX_PIXELS) hist_total++;
      end
      OP_BUILD: begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          run_sum += hist_bins[i];
          level = 0;
          if (hist_total != 0) begin
            level = (run_sum * 255) / hist_total;
            if (level > 255) level = 255;
          end
          eq_table[i] = level[7:0];
        end
        eq_built = 1'b1;
      end
      OP_MAP: begin
        map_expect_q.push_back(ghe_out_t'{mapped_pixel: eq_table[txn.pixel],
                                          table_built: eq_built});
      end
      default: begin
        foreach (hist_bins[i]) hist_bins[i] = 0;
        hist_total = 0;
        eq_built   = 1'b0;
      end
    endcase
  endfunction

  task automatic send_txn(input ghe_op_t op, input logic [7:0] px);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ghe_in_t'{op: op, pixel: px};
    do @(posedge clk); while (in_stall);
    predict_txn(ghe_in_t'{op: op, pixel: px});
  endtask

  // sender goes quiet until every outstanding map result is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (map_expect_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    ghe_out_t exp_out;
    if (rst_n && out_valid && !out_stall) begin
      if (map_expect_q.size() == 0) begin
        $error("unexpected result transaction: mapped_pixel %0d table_built %0d",
               out_data.mapped_pixel, out_data.table_built);
        mismatch_count++;
      end else begin
        exp_out = map_expect_q.pop_front();
        if (out_data.mapped_pixel !== exp_out.mapped_pixel) begin
          $error("mapped_pixel: expected %0d, got %0d",
                 exp_out.mapped_pixel, out_data.mapped_pixel);
          mismatch_count++;
        end
        if (out_data.table_built !== exp_out.table_built) begin
          $error("table_built: expected %0d, got %0d",
                 exp_out.table_built, out_data.table_built);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: a build can keep both channels quiet until the table is done
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("gray_histogram_equalizer_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_map_after_reset();
    send_txn(OP_MAP, 8'd0);
    send_txn(OP_MAP, 8'd255);
    send_txn(OP_MAP, 8'hAA);
  endtask

  // zero total still marks the table as built
  task automatic test_build_empty_histogram();
    send_txn(OP_BUILD, 8'h55);
    send_txn(OP_MAP, 8'd0);
    send_txn(OP_MAP, 8'd255);
  endtask

  task automatic test_sparse_histogram();
    send_txn(OP_ACCUM, 8'd0);
    send_txn(OP_ACCUM, 8'd0);
    send_txn(OP_ACCUM, 8'd128);
    send_txn(OP_ACCUM, 8'd255);
    send_txn(OP_BUILD, 8'd0);
    send_txn(OP_MAP, 8'd0);
    send_txn(OP_MAP, 8'd127);
    send_txn(OP_MAP, 8'd128);
    send_txn(OP_MAP, 8'd254);
    send_txn(OP_MAP, 8'd255);
  endtask

  // clear leaves the table alone but drops the built flag
  task automatic test_clear_keeps_table();
    send_txn(OP_CLEAR, 8'hFF);
    send_txn(OP_MAP, 8'd128);
    send_txn(OP_MAP, 8'd255);
    send_txn(OP_BUILD, 8'd0);
    send_txn(OP_MAP, 8'd128);
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_px;
    int unsigned n_map;
    int unsigned shape;
    int unsigned lo;
    int unsigned hi;
    logic [7:0]  px;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(1) == 0) begin
        send_txn(OP_CLEAR, 8'($urandom));
        sent++;
      end
      n_px  = ($urandom_range(9) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 40);
      shape = $urandom_range(3);
      lo    = $urandom_range(255);
      hi    = (lo + $urandom_range(40) > 255) ? 255 : lo + $urandom_range(40);
      for (int i = 0; i < n_px; i++) begin
        case (shape)
          0:       px = 8'($urandom);
          1:       px = 8'($urandom_range(hi, lo));
          2:       px = 8'(lo);
          default: px = $urandom_range(1) ? 8'd255 : 8'd0;
        endcase
        if ($urandom_range(24) == 0) send_txn(ghe_op_t'($urandom_range(3)), 8'($urandom));
        else send_txn(OP_ACCUM, px);
        sent++;
      end
      // now and then skip the build so maps see a stale table
      if ($urandom_range(9) != 0) begin
        send_txn(OP_BUILD, 8'($urandom));
        sent++;
      end
      n_map = $urandom_range(5, 30);
      for (int i = 0; i < n_map; i++) begin
        send_txn(OP_MAP, 8'($urandom));
        sent++;
      end
    end
  endtask

  // long receiver hold-off while maps keep coming, so the input side backs up
  task automatic test_output_backpressure();
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < 40; i++) send_txn(OP_MAP, 8'($urandom));
    wait_drain();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    foreach (hist_bins[i]) hist_bins[i] = 0;
    foreach (eq_table[i]) eq_table[i] = '0;
    hist_total = 0;
    eq_built   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_map_after_reset();
    test_build_empty_histogram();
    test_sparse_histogram();
    test_clear_keeps_table();
    wait_drain();

    send_idle_pct <= 30;
    recv_idle_pct <= 51;
    test_random_frames(PHASE_ITEMS);
    test_output_backpressure();

    send_idle_pct <= 51;
    recv_idle_pct <= 30;
    test_random_frames(PHASE_ITEMS);
    wait_drain();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    test_random_frames(PHASE_ITEMS);
    test_output_backpressure();

    wait_drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0 && map_expect_q.size() == 0) begin
      $display("gray_histogram_equalizer_tb: clean");
    end else begin
      $display("gray_histogram_equalizer_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ghe_pkg.sv
src/ghe_ram.sv
src/ghe_div.sv
src/gray_histogram_equalizer.sv
sim/gray_histogram_equalizer_tb.sv
